>>> rtl/cpu8_pkg.sv
// ----------------------------------------------------------------------------
// cpu8_pkg
// Shared types and codes for the 8-bit ALU with status flags.
// ----------------------------------------------------------------------------
package cpu8_pkg;

    localparam logic [4:0] FUNC_ADC  = 5'd0;
    localparam logic [4:0] FUNC_SBC  = 5'd1;
    localparam logic [4:0] FUNC_AND  = 5'd2;
    localparam logic [4:0] FUNC_ORA  = 5'd3;
    localparam logic [4:0] FUNC_EOR  = 5'd4;
    localparam logic [4:0] FUNC_ASL  = 5'd5;
    localparam logic [4:0] FUNC_LSR  = 5'd6;
    localparam logic [4:0] FUNC_ROL  = 5'd7;
    localparam logic [4:0] FUNC_ROR  = 5'd8;
    localparam logic [4:0] FUNC_BIT  = 5'd9;
    localparam logic [4:0] FUNC_CMP  = 5'd10;
    localparam logic [4:0] FUNC_INC  = 5'd11;
    localparam logic [4:0] FUNC_DEC  = 5'd12;
    localparam logic [4:0] FUNC_LOAD = 5'd13;
    localparam logic [4:0] FUNC_CLC  = 5'd14;
    localparam logic [4:0] FUNC_SEC  = 5'd15;
    localparam logic [4:0] FUNC_CLD  = 5'd16;
    localparam logic [4:0] FUNC_SED  = 5'd17;
    localparam logic [4:0] FUNC_CLI  = 5'd18;
    localparam logic [4:0] FUNC_SEI  = 5'd19;
    localparam logic [4:0] FUNC_CLV  = 5'd20;

    localparam int unsigned FL_C   = 0;
    localparam int unsigned FL_Z   = 1;
    localparam int unsigned FL_I   = 2;
    localparam int unsigned FL_D   = 3;
    localparam int unsigned FL_B   = 4;
    localparam int unsigned FL_ONE = 5;
    localparam int unsigned FL_V   = 6;
    localparam int unsigned FL_N   = 7;

    localparam logic [7:0] FLAGS_RESET = 8'h20;

    typedef struct packed {
        logic [4:0] func;
        logic [7:0] operand_a;
        logic [7:0] operand_b;
    } op_t;

    typedef struct packed {
        logic [7:0] result;
        logic [7:0] flags;
    } res_t;

endpackage

>>> rtl/cpu8_alu_with_status_flags.sv
// ----------------------------------------------------------------------------
// cpu8_alu_with_status_flags
// 8-bit ALU with a kept N V 1 B D I Z C status byte, binary arithmetic only.
// ----------------------------------------------------------------------------
//  Channel   Direction   Signals                    Payload
//  op        in          op_valid, op_ready         cpu8_pkg::op_t  (func, a, b)
//  res       out         res_valid, res_ready       cpu8_pkg::res_t (result, flags)
//
//  One operation per cycle while res is not stalled: a transfer on op lands in
//  the input register, and from there the ALU and flag logic write the result
//  register and the status byte. res_valid rises when the result register is
//  written, and the result transfers on res from that register.
//  Reset sets the status byte to 0x20 and empties both registers.
//  A stall on res holds the result register; the input register keeps its
//  operation and op_ready falls only while both registers are full and res
//  is stalled.
// ----------------------------------------------------------------------------
module cpu8_alu_with_status_flags (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           op_valid,
    output logic           op_ready,
    input  cpu8_pkg::op_t  op,
    output logic           res_valid,
    input  logic           res_ready,
    output cpu8_pkg::res_t res
);

    logic           in_valid_reg;
    cpu8_pkg::op_t  in_reg;
    logic           out_valid_reg;
    cpu8_pkg::res_t out_reg;
    logic [7:0]     status_reg;

    logic           advance;
    logic [7:0]     a;
    logic [7:0]     b;
    logic           cin;
    logic [7:0]     add_b;
    logic [8:0]     sum;
    logic [8:0]     cmp_diff;
    logic [7:0]     result_next;
    logic [7:0]     status_next;

    assign advance   = in_valid_reg && (!out_valid_reg || res_ready);
    assign op_ready  = !in_valid_reg || advance;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    assign a        = in_reg.operand_a;
    assign b        = in_reg.operand_b;
    assign cin      = status_reg[cpu8_pkg::FL_C];
    assign add_b    = (in_reg.func == cpu8_pkg::FUNC_SBC) ? ~b : b;
    assign sum      = {1'b0, a} + {1'b0, add_b} + {8'd0, cin};
    assign cmp_diff = {1'b0, a} + {1'b0, ~b} + 9'd1;

    always_comb
    begin
        result_next = a;
        status_next = status_reg;
        unique case (in_reg.func) inside
            cpu8_pkg::FUNC_ADC, cpu8_pkg::FUNC_SBC:
            begin
                result_next = sum[7:0];
                status_next[cpu8_pkg::FL_C] = sum[8];
                status_next[cpu8_pkg::FL_V] = (a[7] ^ sum[7]) & (add_b[7] ^ sum[7]);
            end
            cpu8_pkg::FUNC_AND: result_next = a & b;
            cpu8_pkg::FUNC_ORA: result_next = a | b;
            cpu8_pkg::FUNC_EOR: result_next = a ^ b;
            cpu8_pkg::FUNC_ASL:
            begin
                result_next = {a[6:0], 1'b0};
                status_next[cpu8_pkg::FL_C] = a[7];
            end
            cpu8_pkg::FUNC_LSR:
            begin
                result_next = {1'b0, a[7:1]};
                status_next[cpu8_pkg::FL_C] = a[0];
            end
            cpu8_pkg::FUNC_ROL:
            begin
                result_next = {a[6:0], cin};
                status_next[cpu8_pkg::FL_C] = a[7];
            end
            cpu8_pkg::FUNC_ROR:
            begin
                result_next = {cin, a[7:1]};
                status_next[cpu8_pkg::FL_C] = a[0];
            end
            cpu8_pkg::FUNC_INC:  result_next = a + 8'd1;
            cpu8_pkg::FUNC_DEC:  result_next = a - 8'd1;
            cpu8_pkg::FUNC_LOAD: result_next = b;
            cpu8_pkg::FUNC_BIT, cpu8_pkg::FUNC_CMP: result_next = a;
            cpu8_pkg::FUNC_CLC: status_next[cpu8_pkg::FL_C] = 1'b0;
            cpu8_pkg::FUNC_SEC: status_next[cpu8_pkg::FL_C] = 1'b1;
            cpu8_pkg::FUNC_CLD: status_next[cpu8_pkg::FL_D] = 1'b0;
            cpu8_pkg::FUNC_SED: status_next[cpu8_pkg::FL_D] = 1'b1;
            cpu8_pkg::FUNC_CLI: status_next[cpu8_pkg::FL_I] = 1'b0;
            cpu8_pkg::FUNC_SEI: status_next[cpu8_pkg::FL_I] = 1'b1;
            cpu8_pkg::FUNC_CLV: status_next[cpu8_pkg::FL_V] = 1'b0;
            default: result_next = a;
        endcase

        unique case (in_reg.func) inside
            cpu8_pkg::FUNC_ADC, cpu8_pkg::FUNC_SBC, cpu8_pkg::FUNC_AND,
            cpu8_pkg::FUNC_ORA, cpu8_pkg::FUNC_EOR, cpu8_pkg::FUNC_ASL,
            cpu8_pkg::FUNC_LSR, cpu8_pkg::FUNC_ROL, cpu8_pkg::FUNC_ROR,
            cpu8_pkg::FUNC_INC, cpu8_pkg::FUNC_DEC, cpu8_pkg::FUNC_LOAD:
            begin
                status_next[cpu8_pkg::FL_N] = result_next[7];
                status_next[cpu8_pkg::FL_Z] = (result_next == 8'd0);
            end
            cpu8_pkg::FUNC_BIT:
            begin
                status_next[cpu8_pkg::FL_Z] = ((a & b) == 8'd0);
                status_next[cpu8_pkg::FL_N] = b[7];
                status_next[cpu8_pkg::FL_V] = b[6];
            end
            cpu8_pkg::FUNC_CMP:
            begin
                status_next[cpu8_pkg::FL_C] = cmp_diff[8];
                status_next[cpu8_pkg::FL_N] = cmp_diff[7];
                status_next[cpu8_pkg::FL_Z] = (cmp_diff[7:0] == 8'd0);
            end
            default: status_next[cpu8_pkg::FL_N] = status_next[cpu8_pkg::FL_N];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= cpu8_pkg::FLAGS_RESET;
        end
        else
        begin
            if (op_ready)
            begin
                in_valid_reg <= op_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= status_next;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_valid && op_ready)
        begin
            in_reg <= op;
        end
        if (advance)
        begin
            out_reg.result <= result_next;
            out_reg.flags  <= status_next;
        end
    end

endmodule

>>> rtl/cpu8_chk.sv
// ----------------------------------------------------------------------------
// cpu8_chk
// Port-level checks for the 8-bit ALU with status flags.
// ----------------------------------------------------------------------------
module cpu8_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           op_ready,
    input logic           res_valid,
    input logic           res_ready,
    input cpu8_pkg::res_t res
);

    // No operation touches bit five, which comes out of reset set.
    a_one_bit_set: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.flags[cpu8_pkg::FL_ONE])
        else $error("status bit five is clear");

    // The break flag is clear after reset and no operation sets it.
    a_break_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !res.flags[cpu8_pkg::FL_B])
        else $error("break flag is set");

    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped before its transfer");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res))
        else $error("result changed while stalled");

    // The input side only stalls behind a waiting result.
    a_ready_unless_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !op_ready |-> res_valid && !res_ready)
        else $error("op_ready low without a stalled result");

endmodule

bind cpu8_alu_with_status_flags cpu8_chk u_cpu8_chk (.*);

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the 8-bit ALU with N V 1 B D I Z C status flags.
// Directed operations cover the operand extremes, every function, decimal
// mode with binary arithmetic and the unused function codes, followed by
// random operations, some under random idle bursts on both channels.
// A built-in flag model predicts each result byte and status byte, and the
// predictions are checked in order against every transfer on the result
// channel.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [4:0] FUNC_UNUSED_LO = 5'd21;
    localparam logic [4:0] FUNC_UNUSED_HI = 5'd31;
    localparam int RANDOM_OPS = 550;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           op_valid;
    logic           op_ready;
    cpu8_pkg::op_t  op;
    logic           res_valid;
    logic           res_ready;
    cpu8_pkg::res_t res;

    logic [7:0]     status_model;
    cpu8_pkg::res_t expected_q[$];
    int             error_count = 0;
    bit             bursts_on = 1'b1;
    int             stall_left = 0;

    cpu8_alu_with_status_flags DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always #1 clk = ~clk;

    function automatic cpu8_pkg::res_t alu_predict(input cpu8_pkg::op_t item);
        logic [7:0]     a;
        logic [7:0]     b;
        logic [7:0]     addend;
        logic [7:0]     r;
        logic [7:0]     p;
        logic [7:0]     diff;
        logic [8:0]     sum;
        logic           cin;
        logic           nz_from_r;
        cpu8_pkg::res_t out;
        a = item.operand_a;
        b = item.operand_b;
        p = status_model;
        r = a;
        cin = p[cpu8_pkg::FL_C];
        nz_from_r = 1'b1;
        case (item.func) inside
            cpu8_pkg::FUNC_ADC, cpu8_pkg::FUNC_SBC:
            begin
                addend = (item.func == cpu8_pkg::FUNC_SBC) ? ~b : b;
                sum = {1'b0, a} + {1'b0, addend} + {8'd0, cin};
                r = sum[7:0];
                p[cpu8_pkg::FL_C] = sum[8];
                p[cpu8_pkg::FL_V] = (a[7] == addend[7]) && (r[7] != a[7]);
            end
            cpu8_pkg::FUNC_AND: r = a & b;
            cpu8_pkg::FUNC_ORA: r = a | b;
            cpu8_pkg::FUNC_EOR: r = a ^ b;
            cpu8_pkg::FUNC_ASL:
            begin
                r = {a[6:0], 1'b0};
                p[cpu8_pkg::FL_C] = a[7];
            end
            cpu8_pkg::FUNC_LSR:
            begin
                r = {1'b0, a[7:1]};
                p[cpu8_pkg::FL_C] = a[0];
            end
            cpu8_pkg::FUNC_ROL:
            begin
                r = {a[6:0], cin};
                p[cpu8_pkg::FL_C] = a[7];
            end
            cpu8_pkg::FUNC_ROR:
            begin
                r = {cin, a[7:1]};
                p[cpu8_pkg::FL_C] = a[0];
            end
            cpu8_pkg::FUNC_BIT:
            begin
                nz_from_r = 1'b0;
                p[cpu8_pkg::FL_Z] = ((a & b) == 8'd0);
                p[cpu8_pkg::FL_N] = b[7];
                p[cpu8_pkg::FL_V] = b[6];
            end
            cpu8_pkg::FUNC_CMP:
            begin
                nz_from_r = 1'b0;
                diff = a - b;
                p[cpu8_pkg::FL_C] = (a >= b);
                p[cpu8_pkg::FL_N] = diff[7];
                p[cpu8_pkg::FL_Z] = (diff == 8'd0);
            end
            cpu8_pkg::FUNC_INC:  r = a + 8'd1;
            cpu8_pkg::FUNC_DEC:  r = a - 8'd1;
            cpu8_pkg::FUNC_LOAD: r = b;
            default:
            begin
                nz_from_r = 1'b0;
                case (item.func)
                    cpu8_pkg::FUNC_CLC: p[cpu8_pkg::FL_C] = 1'b0;
                    cpu8_pkg::FUNC_SEC: p[cpu8_pkg::FL_C] = 1'b1;
                    cpu8_pkg::FUNC_CLD: p[cpu8_pkg::FL_D] = 1'b0;
                    cpu8_pkg::FUNC_SED: p[cpu8_pkg::FL_D] = 1'b1;
                    cpu8_pkg::FUNC_CLI: p[cpu8_pkg::FL_I] = 1'b0;
                    cpu8_pkg::FUNC_SEI: p[cpu8_pkg::FL_I] = 1'b1;
                    cpu8_pkg::FUNC_CLV: p[cpu8_pkg::FL_V] = 1'b0;
                    default: ;
                endcase
            end
        endcase
        if (nz_from_r)
        begin
            p[cpu8_pkg::FL_N] = r[7];
            p[cpu8_pkg::FL_Z] = (r == 8'd0);
        end
        status_model = p;
        out.result = r;
        out.flags = p;
        return out;
    endfunction

    task automatic send_op(input logic [4:0] func, input logic [7:0] a, input logic [7:0] b);
        cpu8_pkg::op_t item;
        item.func = func;
        item.operand_a = a;
        item.operand_b = b;
        @(negedge clk);
        if (bursts_on && $urandom_range(0, 4) == 0)
        begin
            op_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        op_valid <= 1'b1;
        op <= item;
        @(posedge clk);
        while (!op_ready) @(posedge clk);
        expected_q.push_back(alu_predict(item));
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        op_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] corners[6];
        corners = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 5)];
        return 8'($urandom());
    endfunction

    task automatic test_arith();
        send_op(cpu8_pkg::FUNC_SED, 8'h00, 8'h00);
        send_op(cpu8_pkg::FUNC_CLC, 8'h00, 8'h00);
        send_op(cpu8_pkg::FUNC_ADC, 8'hFF, 8'h01);
        send_op(cpu8_pkg::FUNC_ADC, 8'h7F, 8'h00);
        send_op(cpu8_pkg::FUNC_SEC, 8'h00, 8'h00);
        send_op(cpu8_pkg::FUNC_SBC, 8'h00, 8'h01);
        send_op(cpu8_pkg::FUNC_SBC, 8'h80, 8'h01);
        send_op(cpu8_pkg::FUNC_CLD, 8'h00, 8'h00);
    endtask

    task automatic test_logic();
        send_op(cpu8_pkg::FUNC_AND, 8'hFF, 8'h00);
        send_op(cpu8_pkg::FUNC_ORA, 8'h80, 8'h01);
        send_op(cpu8_pkg::FUNC_EOR, 8'hFF, 8'hFF);
    endtask

    task automatic test_shifts();
        send_op(cpu8_pkg::FUNC_ASL, 8'h80, 8'hFF);
        send_op(cpu8_pkg::FUNC_ROL, 8'h80, 8'h00);
        send_op(cpu8_pkg::FUNC_LSR, 8'h01, 8'hFF);
        send_op(cpu8_pkg::FUNC_ROR, 8'h01, 8'h00);
    endtask

    task automatic test_compare();
        send_op(cpu8_pkg::FUNC_BIT, 8'h00, 8'hC0);
        send_op(cpu8_pkg::FUNC_CMP, 8'h10, 8'h20);
        send_op(cpu8_pkg::FUNC_CMP, 8'hFF, 8'hFF);
    endtask

    task automatic test_inc_dec_load();
        send_op(cpu8_pkg::FUNC_INC, 8'hFF, 8'h00);
        send_op(cpu8_pkg::FUNC_DEC, 8'h00, 8'hFF);
        send_op(cpu8_pkg::FUNC_LOAD, 8'h00, 8'h80);
    endtask

    task automatic test_flag_ops();
        send_op(cpu8_pkg::FUNC_SEI, 8'h5A, 8'h00);
        send_op(cpu8_pkg::FUNC_CLI, 8'hA5, 8'h00);
        send_op(cpu8_pkg::FUNC_CLV, 8'h00, 8'h00);
    endtask

    task automatic test_unused_codes();
        send_op(FUNC_UNUSED_HI, 8'hA5, 8'hFF);
        send_op(FUNC_UNUSED_LO, 8'h5A, 8'h00);
    endtask

    task automatic test_random();
        logic [4:0] func;
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            bursts_on = (i < RANDOM_OPS - 100) && ((i / 60) % 3 != 2);
            if (i == RANDOM_OPS / 2)
                wait_for_results();
            if ($urandom_range(0, 9) == 0)
                func = 5'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
            else
                func = 5'($urandom_range(cpu8_pkg::FUNC_ADC, cpu8_pkg::FUNC_CLV));
            send_op(func, pick_byte(), pick_byte());
        end
    endtask

    initial
    begin
        res_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                res_ready <= 1'b0;
            end
            else if (bursts_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                res_ready <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        cpu8_pkg::res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected transfer on res: result %02h flags %02h",
                       res.result, res.flags);
                error_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (res.result !== want.result)
                begin
                    $error("result: expected %02h, actual %02h", want.result, res.result);
                    error_count++;
                end
                if (res.flags !== want.flags)
                begin
                    $error("flags: expected %02h, actual %02h", want.flags, res.flags);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        op_valid = 1'b0;
        op = '0;
        status_model = cpu8_pkg::FLAGS_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_arith();
        test_logic();
        test_shifts();
        test_compare();
        test_inc_dec_load();
        test_flag_ops();
        test_unused_codes();
        wait_for_results();
        test_random();
        wait_for_results();
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("[cpu8_alu_with_status_flags] OK");
        else
            $display("[cpu8_alu_with_status_flags] ERROR");
        $finish;
    end

    initial
    begin
        #400000;
        $display("[cpu8_alu_with_status_flags] ERROR");
        $finish;
    end

endmodule
